// ----- hdl/ybd_pkg.sv -----
// Shared types and constants for the detector post-processing block.
// No dependencies; ybd_decode, ybd_nms, the top level and the testbench import this package.

package ybd_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam int CntW = 7;
	localparam int MaxClasses = 128;

	localparam logic [CfgIdxW-1:0] RegInputSize = 3'd0;
	localparam logic [CfgIdxW-1:0] RegOrigWidth = 3'd1;
	localparam logic [CfgIdxW-1:0] RegOrigHeight = 3'd2;
	localparam logic [CfgIdxW-1:0] RegConfThresh = 3'd3;
	localparam logic [CfgIdxW-1:0] RegNmsThresh = 3'd4;
	localparam logic [CfgIdxW-1:0] RegNumClasses = 3'd5;

	typedef struct packed {
		logic [11:0] input_size;
		logic [13:0] orig_width;
		logic [13:0] orig_height;
		logic [15:0] conf_thresh;
		logic [15:0] nms_thresh;
		logic [7:0]  num_classes;
	} cfg_t;

	typedef struct packed {
		logic [6:0]         class_id;
		logic [15:0]        confidence;
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic [14:0]        box_w;
		logic [14:0]        box_h;
	} cand_t;

	typedef struct packed {
		cand_t box;
		logic  no_boxes;
		logic  overflow;
		logic  last;
	} res_t;

	typedef struct packed {
		logic            start;
		logic [CntW-1:0] count;
		logic            overflow;
	} nms_ctrl_t;

endpackage

// ----- hdl/ybd_if.sv -----
// Stream interfaces for the tensor element input and the detection output.
// No dependencies.

interface ybd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               end_of_row;
	logic               end_of_frame;
	modport source(output valid, value, end_of_row, end_of_frame, input ready);
	modport sink(input valid, value, end_of_row, end_of_frame, output ready);
endinterface

interface ybd_out_if;
	logic               valid;
	logic               ready;
	logic [6:0]         class_id;
	logic [15:0]        confidence;
	logic signed [15:0] box_x;
	logic signed [15:0] box_y;
	logic [14:0]        box_w;
	logic [14:0]        box_h;
	logic               no_boxes;
	logic               overflow;
	logic               last;
	modport source(output valid, class_id, confidence, box_x, box_y, box_w, box_h,
		no_boxes, overflow, last, input ready);
	modport sink(input valid, class_id, confidence, box_x, box_y, box_w, box_h,
		no_boxes, overflow, last, output ready);
endinterface

// ----- hdl/ybd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ybd_ram #(
	parameter int WIDTH = 85,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/ybd_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies; used by the box mapping sequencer.

module ybd_div #(
	parameter int NW = 50,
	parameter int DW = 29,
	localparam int CW = $clog2(NW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				dvs_q <= divisor;
				cnt_q <= CW'(NW);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

// ----- hdl/ybd_decode.sv -----
// Row intake, confidence test and letterbox box mapping into the candidate store.
// Depends on ybd_pkg and ybd_div.

module ybd_decode
	import ybd_pkg::*;
#(
	parameter int MAX_BOXES = 64,
	parameter int VALUE_FRAC_BITS = 16,
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_value,
	input  logic               in_eor,
	input  logic               in_eof,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output cand_t              wr_data,
	output nms_ctrl_t          nms_ctrl,
	input  logic               nms_done
);
	localparam int F = VALUE_FRAC_BITS;
	localparam int TW = ((48 > 17 + F) ? 48 : 17 + F) + 1;
	localparam int NW = ((49 > 26 + F) ? 49 : 26 + F) + 1;
	localparam int DW = 13 + F;
	localparam logic signed [NW:0] QHi = 32767;
	localparam logic signed [NW:0] QLoPos = -32768;
	localparam logic signed [NW:0] QLoSize = 1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_MUL   = 9'b000000100,
		S_LOAD  = 9'b000001000,
		S_DIV   = 9'b000010000,
		S_FIX   = 9'b000100000,
		S_WRITE = 9'b001000000,
		S_END   = 9'b010000000,
		S_NMS   = 9'b100000000
	} dec_state_t;

	dec_state_t         state_q;
	logic [7:0]         elem_idx_q;
	logic signed [31:0] field_q [4];
	logic signed [31:0] best_q;
	logic [7:0]         best_cls_q;
	logic               eof_q;
	logic [1:0]         k_q;
	logic signed [48:0] prod_a_q;
	logic [25:0]        prod_b_q;
	logic               neg_q;
	logic [15:0]        res_q [4];
	logic [CntW-1:0]    count_q;
	logic               ovf_q;

	logic               accept;
	logic [8:0]         nc;
	logic [7:0]         cls_off;
	logic [11:0]        in_eff;
	logic [13:0]        wd_eff;
	logic [13:0]        ht_eff;
	logic [13:0]        m_eff;
	logic [13:0]        side;
	logic [13:0]        m_minus;
	logic [DW-1:0]      divisor;
	logic signed [TW-1:0] thr_lhs;
	logic signed [TW-1:0] thr_rhs;
	logic               passes;
	logic [47:0]        conf_full;
	logic [15:0]        conf;
	logic signed [33:0] a_sel;
	logic signed [14:0] m_s;
	logic signed [NW-1:0] b_term;
	logic signed [NW-1:0] num;
	logic [NW-1:0]      dividend;
	logic               div_start;
	logic               div_done;
	logic [NW-1:0]      div_q;
	logic [DW-1:0]      div_r;
	logic signed [NW:0] q_fl;
	logic signed [NW:0] q_rnd;
	logic signed [NW:0] q_lo;
	logic [DW-1:0]      r_fl;
	logic [DW:0]        r2;
	logic               up;
	logic [15:0]        fix;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign cls_off = elem_idx_q - 8'd4;

	always_comb begin
		nc = {1'b0, cfg.num_classes};
		if (cfg.num_classes == 8'd0) begin
			nc = 9'd1;
		end else if (nc > 9'(MaxClasses)) begin
			nc = 9'(MaxClasses);
		end
	end

	assign in_eff = (cfg.input_size == 12'd0) ? 12'd1 : cfg.input_size;
	assign wd_eff = (cfg.orig_width == 14'd0) ? 14'd1 : cfg.orig_width;
	assign ht_eff = (cfg.orig_height == 14'd0) ? 14'd1 : cfg.orig_height;
	assign m_eff = (wd_eff > ht_eff) ? wd_eff : ht_eff;
	assign side = k_q[0] ? ht_eff : wd_eff;
	assign m_minus = m_eff - side;
	assign divisor = {in_eff, {(F + 1){1'b0}}};
	assign m_s = $signed({1'b0, m_eff});

	assign thr_lhs = $signed({{(TW - 48){best_q[31]}}, best_q, 16'd0});
	assign thr_rhs = $signed({{(TW - 16 - F){1'b0}}, cfg.conf_thresh, {F{1'b0}}});
	assign passes = thr_lhs > thr_rhs;
	assign conf_full = {best_q, 16'd0} >> F;
	assign conf = (conf_full[47:16] != 32'd0) ? 16'hFFFF : conf_full[15:0];

	always_comb begin
		unique case (k_q)
			2'd0: a_sel = ({{2{field_q[0][31]}}, field_q[0]} <<< 1)
				- {{2{field_q[2][31]}}, field_q[2]};
			2'd1: a_sel = ({{2{field_q[1][31]}}, field_q[1]} <<< 1)
				- {{2{field_q[3][31]}}, field_q[3]};
			2'd2: a_sel = {{2{field_q[2][31]}}, field_q[2]} <<< 1;
			2'd3: a_sel = {{2{field_q[3][31]}}, field_q[3]} <<< 1;
			default: a_sel = '0;
		endcase
	end

	assign b_term = $signed({{(NW - 26 - F){1'b0}}, prod_b_q, {F{1'b0}}});
	assign num = NW'(prod_a_q) - b_term;
	assign dividend = num[NW-1] ? NW'(-num) : NW'(num);
	assign div_start = (state_q == S_LOAD);

	ybd_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dividend),
		.divisor(divisor),
		.done(div_done),
		.quotient(div_q),
		.remainder(div_r)
	);

	always_comb begin
		if (!neg_q) begin
			q_fl = $signed({1'b0, div_q});
			r_fl = div_r;
		end else if (div_r == '0) begin
			q_fl = -$signed({1'b0, div_q});
			r_fl = '0;
		end else begin
			q_fl = -$signed({1'b0, div_q}) - $signed({{NW{1'b0}}, 1'b1});
			r_fl = divisor - div_r;
		end
		r2 = {r_fl, 1'b0};
		up = (r2 > {1'b0, divisor}) || ((r2 == {1'b0, divisor}) && q_fl[0]);
		q_rnd = q_fl + $signed({{NW{1'b0}}, up});
		q_lo = k_q[1] ? QLoSize : QLoPos;
		if (q_rnd > QHi) begin
			fix = 16'h7FFF;
		end else if (q_rnd < q_lo) begin
			fix = q_lo[15:0];
		end else begin
			fix = q_rnd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			elem_idx_q <= '0;
			best_q <= '0;
			best_cls_q <= '0;
			eof_q <= 1'b0;
			k_q <= '0;
			prod_a_q <= '0;
			prod_b_q <= '0;
			neg_q <= 1'b0;
			count_q <= '0;
			ovf_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				field_q[i] <= '0;
				res_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (elem_idx_q < 8'd4) begin
							field_q[elem_idx_q[1:0]] <= in_value;
						end else if (({1'b0, cls_off} < nc)
							&& ((elem_idx_q == 8'd4) || (in_value > best_q))) begin
							best_q <= in_value;
							best_cls_q <= cls_off;
						end
						if (elem_idx_q != 8'hFF) begin
							elem_idx_q <= elem_idx_q + 8'd1;
						end
						if (in_eor || in_eof) begin
							eof_q <= in_eof;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					k_q <= 2'd0;
					if ((elem_idx_q < 8'd5) || !passes) begin
						state_q <= S_END;
					end else if (count_q >= CntW'(MAX_BOXES)) begin
						ovf_q <= 1'b1;
						state_q <= S_END;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_a_q <= a_sel * m_s;
					prod_b_q <= k_q[1] ? 26'd0 : 26'(m_minus) * 26'(in_eff);
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					neg_q <= num[NW-1];
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					res_q[k_q] <= fix;
					if (k_q == 2'd3) begin
						state_q <= S_WRITE;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_WRITE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_END;
				end
				S_END: begin
					elem_idx_q <= '0;
					state_q <= eof_q ? S_NMS : S_IDLE;
				end
				S_NMS: begin
					if (nms_done) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign wr_en = (state_q == S_WRITE);
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = '{
		class_id: best_cls_q[6:0],
		confidence: conf,
		box_x: res_q[0],
		box_y: res_q[1],
		box_w: res_q[2][14:0],
		box_h: res_q[3][14:0]
	};
	assign nms_ctrl = '{
		start: (state_q == S_END) && eof_q,
		count: count_q,
		overflow: ovf_q
	};
endmodule

// ----- hdl/ybd_nms.sv -----
// Greedy non-maximum suppression over the candidate store and result output register.
// Depends on ybd_pkg; reads the candidate RAM through a registered read port.

module ybd_nms
	import ybd_pkg::*;
#(
	parameter int MAX_BOXES = 64,
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nms_ctrl_t     ctrl,
	input  logic [15:0]   nms_thresh,
	output logic          done,
	output logic [AW-1:0] raddr,
	input  cand_t         rdata,
	output logic          out_valid,
	input  logic          out_ready,
	output res_t          out_data
);
	typedef enum logic [13:0] {
		N_IDLE     = 14'b00000000000001,
		N_SEL_RD   = 14'b00000000000010,
		N_SEL_CHK  = 14'b00000000000100,
		N_CUR_RD   = 14'b00000000001000,
		N_CUR_LD   = 14'b00000000010000,
		N_CUR_AREA = 14'b00000000100000,
		N_OV_RD    = 14'b00000001000000,
		N_OV_A     = 14'b00000010000000,
		N_OV_B     = 14'b00000100000000,
		N_OV_C     = 14'b00001000000000,
		N_OV_D     = 14'b00010000000000,
		N_KEEP     = 14'b00100000000000,
		N_FINAL    = 14'b01000000000000,
		N_DONE     = 14'b10000000000000
	} nms_state_t;

	nms_state_t         state_q;
	logic [MAX_BOXES-1:0] proc_q;
	logic [MAX_BOXES-1:0] kept_q;
	logic [CntW-1:0]    count_q;
	logic [CntW-1:0]    j_q;
	logic               found_q;
	logic [15:0]        best_conf_q;
	logic [AW-1:0]      best_idx_q;
	logic               ovf_q;
	cand_t              cur_q;
	cand_t              pend_q;
	logic               pend_valid_q;
	logic [31:0]        area_a_q;
	logic [31:0]        area_b_q;
	logic [31:0]        inter_q;
	logic signed [17:0] dx_q;
	logic signed [17:0] dy_q;
	logic [14:0]        bw_q;
	logic [14:0]        bh_q;
	logic [47:0]        lhs_q;
	logic [47:0]        rhs_q;
	logic               ovalid_q;
	res_t               odata_q;

	logic               cand_ok;
	logic               out_free;
	logic               load;
	res_t               load_data;
	logic signed [17:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	logic signed [17:0] ix1, iy1, ix2, iy2;
	logic [31:0]        uni;

	assign out_free = !ovalid_q || out_ready;
	assign cand_ok = !proc_q[j_q[AW-1:0]] && (!found_q || (rdata.confidence > best_conf_q));

	always_comb begin
		unique case (state_q)
			N_CUR_RD: raddr = best_idx_q;
			default:  raddr = j_q[AW-1:0];
		endcase
	end

	always_comb begin
		ax1 = {{2{cur_q.box_x[15]}}, cur_q.box_x};
		ay1 = {{2{cur_q.box_y[15]}}, cur_q.box_y};
		ax2 = ax1 + $signed({3'd0, cur_q.box_w});
		ay2 = ay1 + $signed({3'd0, cur_q.box_h});
		bx1 = {{2{rdata.box_x[15]}}, rdata.box_x};
		by1 = {{2{rdata.box_y[15]}}, rdata.box_y};
		bx2 = bx1 + $signed({3'd0, rdata.box_w});
		by2 = by1 + $signed({3'd0, rdata.box_h});
		ix1 = (ax1 > bx1) ? ax1 : bx1;
		iy1 = (ay1 > by1) ? ay1 : by1;
		ix2 = (ax2 < bx2) ? ax2 : bx2;
		iy2 = (ay2 < by2) ? ay2 : by2;
		uni = area_a_q + area_b_q - inter_q;
	end

	always_comb begin
		load = 1'b0;
		load_data = '0;
		load_data.overflow = ovf_q;
		if ((state_q == N_KEEP) && pend_valid_q && out_free) begin
			load = 1'b1;
			load_data.box = pend_q;
		end else if ((state_q == N_FINAL) && out_free) begin
			load = 1'b1;
			load_data.last = 1'b1;
			if (pend_valid_q) begin
				load_data.box = pend_q;
			end else begin
				load_data.no_boxes = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			proc_q <= '0;
			kept_q <= '0;
			count_q <= '0;
			j_q <= '0;
			found_q <= 1'b0;
			best_conf_q <= '0;
			best_idx_q <= '0;
			ovf_q <= 1'b0;
			cur_q <= '0;
			pend_q <= '0;
			pend_valid_q <= 1'b0;
			area_a_q <= '0;
			area_b_q <= '0;
			inter_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			bw_q <= '0;
			bh_q <= '0;
			lhs_q <= '0;
			rhs_q <= '0;
			ovalid_q <= 1'b0;
			odata_q <= '0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				odata_q <= load_data;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				N_IDLE: begin
					if (ctrl.start) begin
						proc_q <= '0;
						kept_q <= '0;
						pend_valid_q <= 1'b0;
						count_q <= ctrl.count;
						ovf_q <= ctrl.overflow;
						j_q <= '0;
						found_q <= 1'b0;
						state_q <= (ctrl.count == '0) ? N_FINAL : N_SEL_RD;
					end
				end
				N_SEL_RD: state_q <= N_SEL_CHK;
				N_SEL_CHK: begin
					if (cand_ok) begin
						found_q <= 1'b1;
						best_conf_q <= rdata.confidence;
						best_idx_q <= j_q[AW-1:0];
					end
					if (j_q == count_q - 1'b1) begin
						state_q <= (found_q || cand_ok) ? N_CUR_RD : N_FINAL;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= N_SEL_RD;
					end
				end
				N_CUR_RD: state_q <= N_CUR_LD;
				N_CUR_LD: begin
					cur_q <= rdata;
					proc_q[best_idx_q] <= 1'b1;
					state_q <= N_CUR_AREA;
				end
				N_CUR_AREA: begin
					area_a_q <= 32'(cur_q.box_w) * 32'(cur_q.box_h);
					j_q <= '0;
					state_q <= N_OV_RD;
				end
				N_OV_RD: begin
					if (j_q == count_q) begin
						state_q <= N_KEEP;
					end else if (!kept_q[j_q[AW-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= N_OV_A;
					end
				end
				N_OV_A: begin
					dx_q <= ix2 - ix1;
					dy_q <= iy2 - iy1;
					bw_q <= rdata.box_w;
					bh_q <= rdata.box_h;
					state_q <= N_OV_B;
				end
				N_OV_B: begin
					if ((dx_q > 18'sd0) && (dy_q > 18'sd0)) begin
						inter_q <= 32'(dx_q[15:0]) * 32'(dy_q[15:0]);
					end else begin
						inter_q <= '0;
					end
					area_b_q <= 32'(bw_q) * 32'(bh_q);
					state_q <= N_OV_C;
				end
				N_OV_C: begin
					lhs_q <= {inter_q, 16'd0};
					rhs_q <= 48'(nms_thresh) * 48'(uni);
					state_q <= N_OV_D;
				end
				N_OV_D: begin
					if (lhs_q <= rhs_q) begin
						j_q <= j_q + 1'b1;
						state_q <= N_OV_RD;
					end else begin
						j_q <= '0;
						found_q <= 1'b0;
						state_q <= N_SEL_RD;
					end
				end
				N_KEEP: begin
					kept_q[best_idx_q] <= 1'b1;
					if (!pend_valid_q || out_free) begin
						pend_q <= cur_q;
						pend_valid_q <= 1'b1;
						j_q <= '0;
						found_q <= 1'b0;
						state_q <= N_SEL_RD;
					end
				end
				N_FINAL: begin
					if (out_free) begin
						state_q <= N_DONE;
					end
				end
				N_DONE: state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign done = (state_q == N_DONE);
	assign out_valid = ovalid_q;
	assign out_data = odata_q;
endmodule

// ----- hdl/yolo_box_decode_nms.sv -----
// Detector post-processing: box decode with letterbox undo, then greedy NMS per frame.
// Depends on ybd_pkg, ybd_if, ybd_ram, ybd_div, ybd_decode and ybd_nms.

// Tensor elements enter one beat per cycle while a row is open. A row is closed without
// a box when it fails the confidence test, is short or finds the store full; a passing row
// runs its four box coordinates through one shared restoring divider, one quotient bit per
// cycle. At the end of a frame the NMS sequencer picks each next box by a scan of the
// store, then walks the store again and tests the overlap with each kept box;
// detections leave through an output register. Input is not taken during a row close or
// the NMS pass. The candidate store needs no clearing after reset.

module yolo_box_decode_nms
	import ybd_pkg::*;
#(
	parameter int MAX_BOXES = 64,
	parameter int VALUE_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	ybd_in_if.sink              samples,
	ybd_out_if.source           detections
);
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	cfg_t          cfg_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	cand_t         wr_data;
	logic [AW-1:0] raddr;
	cand_t         rdata;
	nms_ctrl_t     nms_ctrl;
	logic          nms_done;
	res_t          out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_size <= 12'd640;
			cfg_q.orig_width <= 14'd640;
			cfg_q.orig_height <= 14'd640;
			cfg_q.conf_thresh <= 16'd16384;
			cfg_q.nms_thresh <= 16'd29491;
			cfg_q.num_classes <= 8'd80;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegInputSize:  cfg_q.input_size <= cfg_wdata[11:0];
				RegOrigWidth:  cfg_q.orig_width <= cfg_wdata[13:0];
				RegOrigHeight: cfg_q.orig_height <= cfg_wdata[13:0];
				RegConfThresh: cfg_q.conf_thresh <= cfg_wdata;
				RegNmsThresh:  cfg_q.nms_thresh <= cfg_wdata;
				RegNumClasses: cfg_q.num_classes <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	ybd_decode #(
		.MAX_BOXES(MAX_BOXES),
		.VALUE_FRAC_BITS(VALUE_FRAC_BITS)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.in_value(samples.value),
		.in_eor(samples.end_of_row),
		.in_eof(samples.end_of_frame),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.nms_ctrl(nms_ctrl),
		.nms_done(nms_done)
	);

	ybd_ram #(
		.WIDTH($bits(cand_t)),
		.DEPTH(MAX_BOXES)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(raddr),
		.rdata(rdata)
	);

	ybd_nms #(
		.MAX_BOXES(MAX_BOXES)
	) u_nms (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(nms_ctrl),
		.nms_thresh(cfg_q.nms_thresh),
		.done(nms_done),
		.raddr(raddr),
		.rdata(rdata),
		.out_valid(detections.valid),
		.out_ready(detections.ready),
		.out_data(out_data)
	);

	assign detections.class_id = out_data.box.class_id;
	assign detections.confidence = out_data.box.confidence;
	assign detections.box_x = out_data.box.box_x;
	assign detections.box_y = out_data.box.box_y;
	assign detections.box_w = out_data.box.box_w;
	assign detections.box_h = out_data.box.box_h;
	assign detections.no_boxes = out_data.no_boxes;
	assign detections.overflow = out_data.overflow;
	assign detections.last = out_data.last;
endmodule

// ----- hdl/ybd_checker.sv -----
// Port-level checks for the post-processing block, bound to its top level.
// Depends only on the top level's ports.

module ybd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_eof,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  out_class_id,
	input logic [15:0] out_confidence,
	input logic [15:0] out_box_x,
	input logic [15:0] out_box_y,
	input logic [14:0] out_box_w,
	input logic [14:0] out_box_h,
	input logic        out_no_boxes,
	input logic        out_overflow,
	input logic        out_last
);
	logic [87:0] out_bits;

	assign out_bits = {out_class_id, out_confidence, out_box_x, out_box_y, out_box_w,
		out_box_h, out_no_boxes, out_overflow, out_last};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("Detection beat changed while stalled.");

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_no_boxes |-> out_last && (out_class_id == 7'd0)
			&& (out_confidence == 16'd0) && (out_box_w == 15'd0) && (out_box_h == 15'd0))
		else $error("Empty-frame beat is not a zeroed final beat.");

	a_box_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_no_boxes |-> (out_box_w != 15'd0) && (out_box_h != 15'd0))
		else $error("Kept box has zero width or height.");

	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_eof |=> !in_ready)
		else $error("Input taken right after the end of a frame.");
endmodule

bind yolo_box_decode_nms ybd_checker u_ybd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samples.valid),
	.in_ready(samples.ready),
	.in_eof(samples.end_of_frame),
	.out_valid(detections.valid),
	.out_ready(detections.ready),
	.out_class_id(detections.class_id),
	.out_confidence(detections.confidence),
	.out_box_x(detections.box_x),
	.out_box_y(detections.box_y),
	.out_box_w(detections.box_w),
	.out_box_h(detections.box_h),
	.out_no_boxes(detections.no_boxes),
	.out_overflow(detections.overflow),
	.out_last(detections.last)
);

// ----- tb/tb_yolo_box_decode_nms.sv -----
// Self-checking testbench for yolo_box_decode_nms: random tensor frames, box decode and NMS.
// Depends on ybd_pkg, the ybd_in_if and ybd_out_if interfaces and the block itself.
`timescale 1ns / 100ps

module tb_yolo_box_decode_nms
	import ybd_pkg::*;
;

	localparam int FracBits = 16;
	localparam int StoreDepth = 64;
	localparam int StallLimit = 300000;
	localparam longint Scale = 64'd1 << FracBits;

	typedef struct {
		logic signed [31:0] value;
		logic               eor;
		logic               eof;
	} beat_t;

	typedef struct {
		int     cls;
		longint conf, x, y, w, h;
	} det_box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	ybd_in_if  samples_if();
	ybd_out_if det_if();

	yolo_box_decode_nms #(.MAX_BOXES(StoreDepth), .VALUE_FRAC_BITS(FracBits)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples(samples_if),
		.detections(det_if)
	);

	beat_t    pending_q[$];
	res_t     detect_q[$];
	cfg_t     regs;
	int       send_idle = 0;
	int       recv_stall = 0;
	int       errors = 0;
	int       beats_in = 0;
	int       dets_out = 0;
	int       frames = 0;
	int       stall_cnt = 0;

	int       row_pos;
	longint   row_field[4];
	longint   row_score;
	int       row_cls;
	det_box_t boxes[StoreDepth];
	int       box_cnt;
	logic     store_ovf;

	initial begin
		samples_if.valid = 1'b0;
		samples_if.value = '0;
		samples_if.end_of_row = 1'b0;
		samples_if.end_of_frame = 1'b0;
		det_if.ready = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint round_div(longint num, longint den);
		longint q, r;
		q = num / den;
		r = num % den;
		if (r < 0) begin
			r += den;
			q -= 1;
		end
		if (2 * r > den || (2 * r == den && q[0]))
			q += 1;
		return q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int eff_classes();
		int nc;
		nc = regs.num_classes == 0 ? 1 : int'(regs.num_classes);
		return nc > MaxClasses ? MaxClasses : nc;
	endfunction

	function automatic longint eff_input();
		return regs.input_size == 0 ? 1 : longint'(regs.input_size);
	endfunction

	function automatic void clear_row();
		row_pos = 0;
		row_field = '{default: 0};
		row_score = 0;
		row_cls = 0;
	endfunction

	function automatic void close_row();
		longint in_sz, wd, ht, m, den1;
		det_box_t b;
		if (row_pos < 5)
			return;
		if (!(row_score * 65536 > longint'(regs.conf_thresh) * Scale))
			return;
		if (box_cnt >= StoreDepth) begin
			store_ovf = 1'b1;
			return;
		end
		in_sz = eff_input();
		wd = regs.orig_width == 0 ? 1 : longint'(regs.orig_width);
		ht = regs.orig_height == 0 ? 1 : longint'(regs.orig_height);
		m = wd > ht ? wd : ht;
		den1 = in_sz * Scale;
		b.x = clip(round_div((2 * row_field[0] - row_field[2]) * m - (m - wd) * den1,
			2 * den1), -32768, 32767);
		b.y = clip(round_div((2 * row_field[1] - row_field[3]) * m - (m - ht) * den1,
			2 * den1), -32768, 32767);
		b.w = clip(round_div(row_field[2] * m, den1), 1, 32767);
		b.h = clip(round_div(row_field[3] * m, den1), 1, 32767);
		b.conf = clip(row_score, 0, 65535);
		b.cls = row_cls & 127;
		boxes[box_cnt] = b;
		box_cnt++;
	endfunction

	function automatic bit low_overlap(det_box_t a, det_box_t b);
		longint x1, y1, x2, y2, inter, uni;
		x1 = a.x > b.x ? a.x : b.x;
		y1 = a.y > b.y ? a.y : b.y;
		x2 = (a.x + a.w) < (b.x + b.w) ? a.x + a.w : b.x + b.w;
		y2 = (a.y + a.h) < (b.y + b.h) ? a.y + a.h : b.y + b.h;
		inter = (x2 > x1 && y2 > y1) ? (x2 - x1) * (y2 - y1) : 0;
		uni = a.w * a.h + b.w * b.h - inter;
		return inter * 65536 <= longint'(regs.nms_thresh) * uni;
	endfunction

	function automatic void run_suppression();
		int order[StoreDepth];
		int kept[$];
		int j;
		bit keep;
		res_t r;
		for (int i = 0; i < box_cnt; i++) begin
			j = i;
			while (j > 0 && boxes[order[j-1]].conf < boxes[i].conf) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < box_cnt; i++) begin
			keep = 1'b1;
			foreach (kept[k])
				if (!low_overlap(boxes[order[i]], boxes[kept[k]]))
					keep = 1'b0;
			if (keep)
				kept = {kept, order[i]};
		end
		if (kept.size() == 0) begin
			r = '0;
			r.no_boxes = 1'b1;
			r.last = 1'b1;
			r.overflow = store_ovf;
			detect_q = {detect_q, r};
		end
		foreach (kept[k]) begin
			r = '0;
			r.box.class_id = kept[k] >= 0 ? boxes[kept[k]].cls[6:0] : '0;
			r.box.confidence = boxes[kept[k]].conf[15:0];
			r.box.box_x = boxes[kept[k]].x[15:0];
			r.box.box_y = boxes[kept[k]].y[15:0];
			r.box.box_w = boxes[kept[k]].w[14:0];
			r.box.box_h = boxes[kept[k]].h[14:0];
			r.overflow = store_ovf;
			r.last = (k == kept.size() - 1);
			detect_q = {detect_q, r};
		end
	endfunction

	function automatic void predict_beat(beat_t bt);
		longint v;
		v = longint'(bt.value);
		if (row_pos < 4)
			row_field[row_pos] = v;
		else if (row_pos - 4 < eff_classes() && (row_pos == 4 || v > row_score)) begin
			row_score = v;
			row_cls = row_pos - 4;
		end
		if (row_pos < 255)
			row_pos++;
		if (bt.eor || bt.eof) begin
			close_row();
			clear_row();
		end
		if (bt.eof) begin
			run_suppression();
			box_cnt = 0;
			store_ovf = 1'b0;
			frames++;
		end
	endfunction

	function automatic void push_beat(longint v, bit eor, bit eof);
		beat_t bt;
		bt.value = v[31:0];
		bt.eor = eor;
		bt.eof = eof;
		pending_q = {pending_q, bt};
	endfunction

	// One well-formed row; a cluster row lands close to the previous box so that NMS has work.
	task automatic push_row(int n_scores, bit cluster, bit eof, ref longint prev[4]);
		longint span, f[4];
		span = eff_input() * Scale;
		if (cluster) begin
			for (int i = 0; i < 4; i++)
				f[i] = prev[i] + $urandom_range(0, 6 * 65536) - 3 * 65536;
		end else begin
			f[0] = $urandom_range(0, span);
			f[1] = $urandom_range(0, span);
			f[2] = $urandom_range(1, span / 2 + 65536);
			f[3] = $urandom_range(1, span / 2 + 65536);
		end
		prev = f;
		for (int i = 0; i < 4; i++)
			push_beat(f[i], 1'b0, 1'b0);
		for (int i = 0; i < n_scores; i++)
			push_beat($urandom_range(0, 98304), i == n_scores - 1,
				eof && i == n_scores - 1);
	endtask

	task automatic random_frame(int n_rows);
		longint prev[4];
		int len;
		prev = '{default: 0};
		for (int r = 0; r < n_rows; r++) begin
			if ($urandom_range(0, 99) < 85) begin
				len = eff_classes() + 2 > 8 ? 8 : eff_classes() + 2;
				push_row($urandom_range(1, len), r > 0 && $urandom_range(0, 1),
					r == n_rows - 1, prev);
			end else begin
				len = $urandom_range(1, 9);
				for (int i = 0; i < len; i++)
					push_beat(longint'($urandom), (i == len - 1) | $urandom_range(0, 1) == 0,
						r == n_rows - 1 && i == len - 1);
			end
		end
		if (n_rows == 0)
			push_beat(longint'($urandom), $urandom_range(0, 1), 1'b1);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CfgDataW-1:0];
		case (idx)
			RegInputSize:  regs.input_size = val[11:0];
			RegOrigWidth:  regs.orig_width = val[13:0];
			RegOrigHeight: regs.orig_height = val[13:0];
			RegConfThresh: regs.conf_thresh = val[15:0];
			RegNmsThresh:  regs.nms_thresh = val[15:0];
			RegNumClasses: regs.num_classes = val[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(int in_sz, int ow, int oh, int ct, int nt, int nc);
		write_reg(RegInputSize, in_sz);
		write_reg(RegOrigWidth, ow);
		write_reg(RegOrigHeight, oh);
		write_reg(RegConfThresh, ct);
		write_reg(RegNmsThresh, nt);
		write_reg(RegNumClasses, nc);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || samples_if.valid || detect_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic int pick(int lo, int hi, int odd);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2: return odd;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				samples_if.valid <= 1'b1;
				samples_if.value <= pending_q[0].value;
				samples_if.end_of_row <= pending_q[0].eor;
				samples_if.end_of_frame <= pending_q[0].eof;
				void'(pending_q.pop_front());
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		det_if.ready <= arst_n && $urandom_range(0, 99) >= recv_stall;
	end

	always @(posedge clk) begin
		beat_t bt;
		if (arst_n && samples_if.valid && samples_if.ready) begin
			bt.value = samples_if.value;
			bt.eor = samples_if.end_of_row;
			bt.eof = samples_if.end_of_frame;
			predict_beat(bt);
			beats_in++;
		end
	end

	task automatic check_field(string name, longint e, longint a);
		if (e != a) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t got, exp_r;
		if (arst_n && det_if.valid && det_if.ready) begin
			got.box.class_id = det_if.class_id;
			got.box.confidence = det_if.confidence;
			got.box.box_x = det_if.box_x;
			got.box.box_y = det_if.box_y;
			got.box.box_w = det_if.box_w;
			got.box.box_h = det_if.box_h;
			got.no_boxes = det_if.no_boxes;
			got.overflow = det_if.overflow;
			got.last = det_if.last;
			dets_out++;
			if (detect_q.size() == 0) begin
				$display("%0t: unexpected detection beat: expected none, actual %h",
					$realtime, got);
				errors++;
			end else begin
				exp_r = detect_q.pop_front();
				check_field("class_id", exp_r.box.class_id, got.box.class_id);
				check_field("confidence", exp_r.box.confidence, got.box.confidence);
				check_field("box_x", exp_r.box.box_x, got.box.box_x);
				check_field("box_y", exp_r.box.box_y, got.box.box_y);
				check_field("box_w", exp_r.box.box_w, got.box.box_w);
				check_field("box_h", exp_r.box.box_h, got.box.box_h);
				check_field("no_boxes", exp_r.no_boxes, got.no_boxes);
				check_field("overflow", exp_r.overflow, got.overflow);
				check_field("last", exp_r.last, got.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (det_if.valid && det_if.ready) || cfg_we)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= StallLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		longint prev[4];
		int phase;
		regs = '{input_size: 640, orig_width: 640, orig_height: 640, conf_thresh: 16384,
			nms_thresh: 29491, num_classes: 80};
		clear_row();
		box_cnt = 0;
		store_ovf = 1'b0;
		prev = '{default: 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		write_all(640, 640, 480, 16384, 29491, 3);
		// Tied scores pick the earlier class; coordinates at the extremes saturate.
		push_beat(32'sh7fffffff, 0, 0);
		push_beat(-64'sd2147483648, 0, 0);
		push_beat(32'sh7fffffff, 0, 0);
		push_beat(1, 0, 0);
		push_beat(65536, 0, 0);
		push_beat(65536, 0, 0);
		push_beat(-64'sd2147483648, 1, 0);
		// A short row, then a row with a score beyond the class count.
		push_beat(100, 0, 0);
		push_beat(200, 0, 0);
		push_beat(300, 1, 0);
		push_beat(320 * 65536, 0, 0);
		push_beat(240 * 65536, 0, 0);
		push_beat(50 * 65536, 0, 0);
		push_beat(40 * 65536, 0, 0);
		push_beat(30000, 0, 0);
		push_beat(50000, 0, 0);
		push_beat(20000, 0, 0);
		push_beat(65535, 1, 0);
		// The frame ends inside an open row.
		push_beat(322 * 65536, 0, 0);
		push_beat(241 * 65536, 0, 0);
		push_beat(50 * 65536, 0, 0);
		push_beat(41 * 65536, 0, 0);
		push_beat(65000, 0, 1);
		// An empty frame.
		push_beat(7, 0, 1);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1) ? 80 : ((phase == 3) ? 24 : 0);
			recv_stall = (phase == 2) ? 80 : ((phase == 3) ? 24 : 0);
			if (phase == 2) begin
				// Fill the store past its capacity with passing boxes.
				write_all(640, 0, 8192, 0, 65535, 1);
				for (int r = 0; r < StoreDepth + 3; r++)
					push_row(1, 1'b0, r == StoreDepth + 2, prev);
			end else begin
				write_all(pick(32, 2048, phase % 2 ? 0 : 4095), pick(1, 8192, 0),
					pick(1, 8192, 0), pick(0, 65535, 8192), pick(0, 65535, 32768),
					pick(1, 6, phase % 3 ? 0 : 200));
				for (int f = 0; f < 2; f++)
					random_frame($urandom_range(0, 4));
			end
			drain();
		end

		$display("Covered %0d frames from %0d input beats in %0d phases, %0d detections.",
			frames, beats_in, phase, dets_out);
		if (errors == 0 && detect_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
